[src/assert_macros.svh]
// ---------------------------------------------------------------------------
// assert_macros.svh
// Assertion macros shared by the RTL; they expand to nothing when SYNTH is set.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH
// Clocked assertion, disabled while reset is asserted.
`define ASSERT_AT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed");
// Clocked assertion, checked in every cycle.
`define ASSERT_ALWAYS(label, clk, prop) \
    label: assert property (@(posedge clk) prop) else $error("assertion failed");
`else
`define ASSERT_AT(label, clk, rst_n, prop)
`define ASSERT_ALWAYS(label, clk, prop)
`endif

`endif

[src/sle_pkg.sv]
// ---------------------------------------------------------------------------
// sle_pkg
// Types, constants and controller/datapath interface structs for the list engine.
// ---------------------------------------------------------------------------
package sle_pkg;

    localparam int DEPTH_DEF  = 128;
    localparam int OP_W       = 3;
    localparam int POS_W      = 8;
    localparam int VAL_W      = 32;
    localparam int STAT_W     = 2;
    localparam int LEN_W      = 8;
    localparam int IN_DATA_W  = POS_W + VAL_W;
    localparam int OUT_DATA_W = VAL_W + LEN_W;

    typedef enum logic [OP_W-1:0] {
        OP_GET    = 3'd0,
        OP_LOCATE = 3'd1,
        OP_PRED   = 3'd2,
        OP_SUCC   = 3'd3,
        OP_INSERT = 3'd4,
        OP_DELETE = 3'd5,
        OP_CLEAR  = 3'd6
    } t_op;

    typedef enum logic [STAT_W-1:0] {
        ST_OK   = 2'd0,
        ST_MISS = 2'd1,
        ST_FULL = 2'd2
    } t_status;

    typedef enum logic [3:0] {
        S_IDLE,
        S_CHECK,
        S_GET_WAIT,
        S_SCAN,
        S_SUCC_WAIT,
        S_DEL_HEAD,
        S_DEL_SHIFT,
        S_INS_SHIFT,
        S_DONE
    } t_state;

    typedef enum logic [1:0] {RD_NONE, RD_POS, RD_IDX} t_rd_mode;
    typedef enum logic [2:0] {IDX_HOLD, IDX_ZERO, IDX_POS, IDX_TOP, IDX_INC} t_idx_mode;
    typedef enum logic [1:0] {WR_NONE, WR_UP, WR_DOWN, WR_VAL} t_wr_mode;
    typedef enum logic [1:0] {CNT_HOLD, CNT_INC, CNT_DEC, CNT_CLEAR} t_cnt_mode;
    typedef enum logic [2:0] {
        RES_HOLD, RES_MISS, RES_FULL, RES_DATA, RES_PREV, RES_POS, RES_OK
    } t_res_mode;

    typedef struct packed {
        logic      capture;
        t_rd_mode  rd;
        t_idx_mode idx;
        t_wr_mode  wr;
        logic      more_load;
        logic      more_step;
        t_cnt_mode cnt;
        t_res_mode res;
        logic      emit;
    } t_sle_cmd;

    typedef struct packed {
        t_op  op;
        logic pos_ok;
        logic ins_ok;
        logic full;
        logic empty;
        logic issue_ok;
        logic more;
        logic dv;
        logic match;
        logic last;
        logic has_pred;
        logic has_succ;
        logic out_free;
    } t_sle_stat;

endpackage

[src/sle_ctrl.sv]
// ---------------------------------------------------------------------------
// sle_ctrl
// Sequencer for the list engine: range checks, search walk, shift walks, result.
// ---------------------------------------------------------------------------
module sle_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_s_tvalid,
    output logic               o_s_tready,
    input  sle_pkg::t_sle_stat i_stat,
    output sle_pkg::t_sle_cmd  o_cmd
);

    sle_pkg::t_state r_state;
    sle_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= sle_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state         = r_state;
        o_s_tready      = 1'b0;
        o_cmd.capture   = 1'b0;
        o_cmd.rd        = sle_pkg::RD_NONE;
        o_cmd.idx       = sle_pkg::IDX_HOLD;
        o_cmd.wr        = sle_pkg::WR_NONE;
        o_cmd.more_load = 1'b0;
        o_cmd.more_step = 1'b0;
        o_cmd.cnt       = sle_pkg::CNT_HOLD;
        o_cmd.res       = sle_pkg::RES_HOLD;
        o_cmd.emit      = 1'b0;
        unique case (r_state)
            sle_pkg::S_IDLE: begin
                o_s_tready = 1'b1;
                if (i_s_tvalid) begin
                    o_cmd.capture = 1'b1;
                    n_state       = sle_pkg::S_CHECK;
                end
            end
            sle_pkg::S_CHECK: begin
                n_state = sle_pkg::S_DONE;
                unique case (i_stat.op) inside
                    sle_pkg::OP_GET: begin
                        if (i_stat.pos_ok) begin
                            o_cmd.rd = sle_pkg::RD_POS;
                            n_state  = sle_pkg::S_GET_WAIT;
                        end else begin
                            o_cmd.res = sle_pkg::RES_MISS;
                        end
                    end
                    sle_pkg::OP_LOCATE, sle_pkg::OP_PRED, sle_pkg::OP_SUCC: begin
                        if (i_stat.empty) begin
                            o_cmd.res = sle_pkg::RES_MISS;
                        end else begin
                            o_cmd.idx = sle_pkg::IDX_ZERO;
                            n_state   = sle_pkg::S_SCAN;
                        end
                    end
                    sle_pkg::OP_INSERT: begin
                        if (!i_stat.ins_ok) begin
                            o_cmd.res = sle_pkg::RES_MISS;
                        end else if (i_stat.full) begin
                            o_cmd.res = sle_pkg::RES_FULL;
                        end else begin
                            o_cmd.idx       = sle_pkg::IDX_TOP;
                            o_cmd.more_load = 1'b1;
                            n_state         = sle_pkg::S_INS_SHIFT;
                        end
                    end
                    sle_pkg::OP_DELETE: begin
                        if (i_stat.pos_ok) begin
                            o_cmd.rd  = sle_pkg::RD_POS;
                            o_cmd.idx = sle_pkg::IDX_POS;
                            n_state   = sle_pkg::S_DEL_HEAD;
                        end else begin
                            o_cmd.res = sle_pkg::RES_MISS;
                        end
                    end
                    sle_pkg::OP_CLEAR: begin
                        o_cmd.cnt = sle_pkg::CNT_CLEAR;
                        o_cmd.res = sle_pkg::RES_OK;
                    end
                    default: begin
                        o_cmd.res = sle_pkg::RES_MISS;
                    end
                endcase
            end
            sle_pkg::S_GET_WAIT: begin
                o_cmd.res = sle_pkg::RES_DATA;
                n_state   = sle_pkg::S_DONE;
            end
            sle_pkg::S_SCAN: begin
                if (i_stat.issue_ok) begin
                    o_cmd.rd  = sle_pkg::RD_IDX;
                    o_cmd.idx = sle_pkg::IDX_INC;
                end
                if (i_stat.match) begin
                    n_state = sle_pkg::S_DONE;
                    unique case (i_stat.op)
                        sle_pkg::OP_LOCATE: begin
                            o_cmd.res = sle_pkg::RES_POS;
                        end
                        sle_pkg::OP_PRED: begin
                            o_cmd.res = i_stat.has_pred ? sle_pkg::RES_PREV
                                                        : sle_pkg::RES_MISS;
                        end
                        sle_pkg::OP_SUCC: begin
                            if (i_stat.has_succ) begin
                                n_state = sle_pkg::S_SUCC_WAIT;
                            end else begin
                                o_cmd.res = sle_pkg::RES_MISS;
                            end
                        end
                        default: begin
                            o_cmd.res = sle_pkg::RES_MISS;
                        end
                    endcase
                end else if (i_stat.dv && i_stat.last) begin
                    o_cmd.res = sle_pkg::RES_MISS;
                    n_state   = sle_pkg::S_DONE;
                end
            end
            sle_pkg::S_SUCC_WAIT: begin
                o_cmd.res = sle_pkg::RES_DATA;
                n_state   = sle_pkg::S_DONE;
            end
            sle_pkg::S_DEL_HEAD: begin
                o_cmd.res = sle_pkg::RES_DATA;
                if (i_stat.issue_ok) begin
                    o_cmd.rd  = sle_pkg::RD_IDX;
                    o_cmd.idx = sle_pkg::IDX_INC;
                end
                n_state = sle_pkg::S_DEL_SHIFT;
            end
            sle_pkg::S_DEL_SHIFT: begin
                if (i_stat.dv) begin
                    o_cmd.wr = sle_pkg::WR_DOWN;
                end
                if (i_stat.issue_ok) begin
                    o_cmd.rd  = sle_pkg::RD_IDX;
                    o_cmd.idx = sle_pkg::IDX_INC;
                end
                if (!i_stat.dv && !i_stat.issue_ok) begin
                    o_cmd.cnt = sle_pkg::CNT_DEC;
                    n_state   = sle_pkg::S_DONE;
                end
            end
            sle_pkg::S_INS_SHIFT: begin
                if (i_stat.dv) begin
                    o_cmd.wr = sle_pkg::WR_UP;
                end
                if (i_stat.more) begin
                    o_cmd.rd        = sle_pkg::RD_IDX;
                    o_cmd.more_step = 1'b1;
                end
                if (!i_stat.more && !i_stat.dv) begin
                    o_cmd.wr  = sle_pkg::WR_VAL;
                    o_cmd.cnt = sle_pkg::CNT_INC;
                    o_cmd.res = sle_pkg::RES_OK;
                    n_state   = sle_pkg::S_DONE;
                end
            end
            sle_pkg::S_DONE: begin
                if (i_stat.out_free) begin
                    o_cmd.emit = 1'b1;
                    n_state    = sle_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = sle_pkg::S_IDLE;
            end
        endcase
    end

endmodule

[src/sle_datapath.sv]
// ---------------------------------------------------------------------------
// sle_datapath
// Element store, length count, walk counters, result and output registers.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module sle_datapath #(
    parameter int DEPTH = sle_pkg::DEPTH_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  sle_pkg::t_sle_cmd               i_cmd,
    output sle_pkg::t_sle_stat              o_stat,
    input  logic [sle_pkg::IN_DATA_W-1:0]   i_s_tdata,
    input  logic [sle_pkg::OP_W-1:0]        i_s_tuser,
    input  logic                            i_m_tready,
    output logic                            o_m_tvalid,
    output logic [sle_pkg::OUT_DATA_W-1:0]  o_m_tdata,
    output logic [sle_pkg::STAT_W-1:0]      o_m_tuser
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam int LW = (CW > sle_pkg::POS_W) ? CW : sle_pkg::POS_W;

    logic [sle_pkg::VAL_W-1:0] r_mem [DEPTH];

    sle_pkg::t_op               r_op;
    logic [sle_pkg::POS_W-1:0]  r_pos;
    logic [sle_pkg::VAL_W-1:0]  r_val;
    logic [CW-1:0]              r_cnt;
    logic [CW-1:0]              n_cnt;
    logic [CW-1:0]              r_idx;
    logic [CW-1:0]              n_idx;
    logic [CW-1:0]              r_didx;
    logic                       r_dv;
    logic                       r_more;
    logic                       n_more;
    logic [sle_pkg::VAL_W-1:0]  r_rdata;
    logic [sle_pkg::VAL_W-1:0]  r_prev;
    logic [sle_pkg::VAL_W-1:0]  r_res;
    sle_pkg::t_status           r_stat;
    logic                       r_ov;
    logic [sle_pkg::VAL_W-1:0]  r_out_res;
    sle_pkg::t_status           r_out_stat;
    logic [sle_pkg::LEN_W-1:0]  r_out_len;

    logic [LW-1:0]              pos_w;
    logic [LW-1:0]              cnt_w;
    logic [LW-1:0]              pos_m1;
    logic [CW-1:0]              didx_p1;
    logic                       more_hit;
    logic                       rd_en;
    logic [AW-1:0]              rd_addr;
    logic                       wr_en;
    logic [AW-1:0]              wr_addr;
    logic [sle_pkg::VAL_W-1:0]  wr_data;

    assign pos_w    = LW'(r_pos);
    assign cnt_w    = LW'(r_cnt);
    assign pos_m1   = pos_w - LW'(1);
    assign didx_p1  = r_didx + CW'(1);
    assign more_hit = (r_idx == CW'(pos_m1));

    always_comb begin
        o_stat.op       = r_op;
        o_stat.pos_ok   = (r_pos != '0) && (pos_m1 < cnt_w);
        o_stat.ins_ok   = (r_pos != '0) && (pos_m1 <= cnt_w);
        o_stat.full     = (r_cnt == CW'(DEPTH));
        o_stat.empty    = (r_cnt == '0);
        o_stat.issue_ok = (r_idx < r_cnt);
        o_stat.more     = r_more;
        o_stat.dv       = r_dv;
        o_stat.match    = r_dv && (r_rdata == r_val);
        o_stat.last     = (didx_p1 == r_cnt);
        o_stat.has_pred = (r_didx != '0);
        o_stat.has_succ = (didx_p1 < r_cnt);
        o_stat.out_free = !r_ov || i_m_tready;
    end

    always_comb begin
        rd_en   = 1'b0;
        rd_addr = r_idx[AW-1:0];
        unique case (i_cmd.rd)
            sle_pkg::RD_NONE: ;
            sle_pkg::RD_POS: begin
                rd_en   = 1'b1;
                rd_addr = AW'(pos_m1);
            end
            sle_pkg::RD_IDX: begin
                rd_en = 1'b1;
            end
            default: ;
        endcase
    end

    always_comb begin
        wr_en   = 1'b0;
        wr_addr = AW'(pos_m1);
        wr_data = r_rdata;
        unique case (i_cmd.wr)
            sle_pkg::WR_NONE: ;
            sle_pkg::WR_UP: begin
                wr_en   = 1'b1;
                wr_addr = AW'(didx_p1);
            end
            sle_pkg::WR_DOWN: begin
                wr_en   = 1'b1;
                wr_addr = AW'(r_didx - CW'(1));
            end
            sle_pkg::WR_VAL: begin
                wr_en   = 1'b1;
                wr_data = r_val;
            end
            default: ;
        endcase
    end

    always_comb begin
        n_idx = r_idx;
        unique case (i_cmd.idx)
            sle_pkg::IDX_HOLD: ;
            sle_pkg::IDX_ZERO: n_idx = '0;
            sle_pkg::IDX_POS:  n_idx = CW'(r_pos);
            sle_pkg::IDX_TOP:  n_idx = r_cnt - CW'(1);
            sle_pkg::IDX_INC:  n_idx = r_idx + CW'(1);
            default: ;
        endcase
        if (i_cmd.more_step && !more_hit) begin
            n_idx = r_idx - CW'(1);
        end
    end

    always_comb begin
        n_more = r_more;
        if (i_cmd.more_load) begin
            n_more = (pos_m1 < cnt_w);
        end else if (i_cmd.more_step && more_hit) begin
            n_more = 1'b0;
        end
    end

    always_comb begin
        n_cnt = r_cnt;
        unique case (i_cmd.cnt)
            sle_pkg::CNT_HOLD:  ;
            sle_pkg::CNT_INC:   n_cnt = r_cnt + CW'(1);
            sle_pkg::CNT_DEC:   n_cnt = r_cnt - CW'(1);
            sle_pkg::CNT_CLEAR: n_cnt = '0;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            r_rdata <= r_mem[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_dv   <= 1'b0;
            r_more <= 1'b0;
            r_ov   <= 1'b0;
        end else begin
            r_cnt  <= n_cnt;
            r_dv   <= rd_en;
            r_more <= n_more;
            if (i_cmd.emit) begin
                r_ov <= 1'b1;
            end else if (i_m_tready) begin
                r_ov <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx <= n_idx;
        if (i_cmd.capture) begin
            r_op  <= sle_pkg::t_op'(i_s_tuser);
            r_pos <= i_s_tdata[sle_pkg::POS_W-1:0];
            r_val <= i_s_tdata[sle_pkg::IN_DATA_W-1:sle_pkg::POS_W];
        end
        if (rd_en) begin
            r_didx <= (i_cmd.rd == sle_pkg::RD_POS) ? CW'(pos_m1) : r_idx;
        end
        if (r_dv) begin
            r_prev <= r_rdata;
        end
        unique case (i_cmd.res)
            sle_pkg::RES_HOLD: ;
            sle_pkg::RES_MISS: begin
                r_res  <= '0;
                r_stat <= sle_pkg::ST_MISS;
            end
            sle_pkg::RES_FULL: begin
                r_res  <= '0;
                r_stat <= sle_pkg::ST_FULL;
            end
            sle_pkg::RES_DATA: begin
                r_res  <= r_rdata;
                r_stat <= sle_pkg::ST_OK;
            end
            sle_pkg::RES_PREV: begin
                r_res  <= r_prev;
                r_stat <= sle_pkg::ST_OK;
            end
            sle_pkg::RES_POS: begin
                r_res  <= sle_pkg::VAL_W'(didx_p1);
                r_stat <= sle_pkg::ST_OK;
            end
            sle_pkg::RES_OK: begin
                r_res  <= '0;
                r_stat <= sle_pkg::ST_OK;
            end
            default: ;
        endcase
        if (i_cmd.emit) begin
            r_out_res  <= r_res;
            r_out_stat <= r_stat;
            r_out_len  <= sle_pkg::LEN_W'(r_cnt);
        end
    end

    assign o_m_tvalid = r_ov;
    assign o_m_tdata  = {r_out_len, r_out_res};
    assign o_m_tuser  = r_out_stat;

    `ASSERT_AT(a_rw_apart, i_clk, i_rst_n, (wr_en && rd_en) |-> (wr_addr != rd_addr))
    `ASSERT_AT(a_emit_free, i_clk, i_rst_n, i_cmd.emit |-> (!r_ov || i_m_tready))
    `ASSERT_AT(a_data_in_list, i_clk, i_rst_n, r_dv |-> (r_didx < r_cnt))

endmodule

[src/sequential_list_engine.sv]
// One item at a time: the single read port of the store walks one element per cycle.
// o_s_tready rises in the cycle after the result is loaded into the output register; a held result stalls it.
// Reset (synchronous, i_rst_n low) empties the list; store contents are not cleared.
// ---------------------------------------------------------------------------
// sequential_list_engine
// Ordered list of signed 32-bit elements with get, search, insert and delete.
// ---------------------------------------------------------------------------
module sequential_list_engine #(
    parameter int DEPTH = sle_pkg::DEPTH_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_s_tvalid,
    output logic                            o_s_tready,
    input  logic [sle_pkg::IN_DATA_W-1:0]   i_s_tdata,   // position[7:0], value[39:8]
    input  logic [sle_pkg::OP_W-1:0]        i_s_tuser,   // operation[2:0]
    output logic                            o_m_tvalid,
    input  logic                            i_m_tready,
    output logic [sle_pkg::OUT_DATA_W-1:0]  o_m_tdata,   // result_value[31:0], list_length[39:32]
    output logic [sle_pkg::STAT_W-1:0]      o_m_tuser    // status[1:0]
);

    sle_pkg::t_sle_cmd  cmd;
    sle_pkg::t_sle_stat stat;

    sle_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    sle_datapath #(
        .DEPTH (DEPTH)
    ) u_datapath (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (cmd),
        .o_stat     (stat),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .i_m_tready (i_m_tready),
        .o_m_tvalid (o_m_tvalid),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser)
    );

endmodule

[tb/sequential_list_engine_test.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// sequential_list_engine_test
// Drives get, locate, neighbour, insert, delete and clear items into the list
// engine, including a fill to full capacity, and checks every result against
// a shadow copy of the list kept in the testbench.
// ---------------------------------------------------------------------------
module sequential_list_engine_test;

    localparam int          LIST_DEPTH  = sle_pkg::DEPTH_DEF;
    localparam int          TOTAL_ITEMS = 1550;
    localparam int          QUIET_TAIL  = 150;
    localparam logic [sle_pkg::OP_W-1:0] OP_UNUSED = 3'd7;

    typedef struct {
        logic [sle_pkg::OP_W-1:0]  op;
        logic [sle_pkg::POS_W-1:0] pos;
        logic [sle_pkg::VAL_W-1:0] val;
        bit                        drain;
    } t_list_req;

    typedef struct {
        sle_pkg::t_status          status;
        logic [sle_pkg::VAL_W-1:0] value;
        logic [sle_pkg::LEN_W-1:0] len;
    } t_list_ans;

    logic                           i_clk = 1'b0;
    logic                           i_rst_n = 1'b0;
    logic                           s_valid = 1'b0;
    logic                           s_ready;
    logic [sle_pkg::IN_DATA_W-1:0]  s_data = '0;
    logic [sle_pkg::OP_W-1:0]       s_user = '0;
    logic                           m_valid;
    logic                           m_ready = 1'b0;
    logic [sle_pkg::OUT_DATA_W-1:0] m_data;
    logic [sle_pkg::STAT_W-1:0]     m_user;

    t_list_req                 list_requests[$];
    t_list_ans                 pending_answers[$];
    logic [sle_pkg::VAL_W-1:0] shadow_elems[LIST_DEPTH];
    int                        shadow_len = 0;
    logic [sle_pkg::VAL_W-1:0] value_pool[8];
    int                        plan_len = 0;
    int                        issued = 0;
    int                        rcv_cnt = 0;
    int                        errors = 0;
    int                        send_gap = 0;
    bit                        send_idling = 1'b1;
    bit                        tail_quiet = 1'b0;
    t_list_req                 cur_req;

    sequential_list_engine uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (s_valid),
        .o_s_tready (s_ready),
        .i_s_tdata  (s_data),
        .i_s_tuser  (s_user),
        .o_m_tvalid (m_valid),
        .i_m_tready (m_ready),
        .o_m_tdata  (m_data),
        .o_m_tuser  (m_user)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // Shadow of the list: apply one item and return the answer it gives.
    function automatic void apply_list_op(input t_list_req r, output t_list_ans a);
        int idx;
        int p;
        p = int'(r.pos);
        idx = -1;
        for (int k = 0; k < shadow_len; k++) begin
            if (idx < 0 && shadow_elems[k] == r.val) begin
                idx = k;
            end
        end
        a.status = sle_pkg::ST_MISS;
        a.value  = '0;
        case (r.op)
            sle_pkg::OP_GET: begin
                if (p >= 1 && p <= shadow_len) begin
                    a.value  = shadow_elems[p-1];
                    a.status = sle_pkg::ST_OK;
                end
            end
            sle_pkg::OP_LOCATE: begin
                if (idx >= 0) begin
                    a.value  = sle_pkg::VAL_W'(idx + 1);
                    a.status = sle_pkg::ST_OK;
                end
            end
            sle_pkg::OP_PRED: begin
                if (idx > 0) begin
                    a.value  = shadow_elems[idx-1];
                    a.status = sle_pkg::ST_OK;
                end
            end
            sle_pkg::OP_SUCC: begin
                if (idx >= 0 && idx + 1 < shadow_len) begin
                    a.value  = shadow_elems[idx+1];
                    a.status = sle_pkg::ST_OK;
                end
            end
            sle_pkg::OP_INSERT: begin
                if (p >= 1 && p <= shadow_len + 1) begin
                    if (shadow_len >= LIST_DEPTH) begin
                        a.status = sle_pkg::ST_FULL;
                    end else begin
                        for (int j = shadow_len; j >= p; j--) begin
                            shadow_elems[j] = shadow_elems[j-1];
                        end
                        shadow_elems[p-1] = r.val;
                        shadow_len++;
                        a.status = sle_pkg::ST_OK;
                    end
                end
            end
            sle_pkg::OP_DELETE: begin
                if (p >= 1 && p <= shadow_len) begin
                    a.value = shadow_elems[p-1];
                    for (int j = p - 1; j + 1 < shadow_len; j++) begin
                        shadow_elems[j] = shadow_elems[j+1];
                    end
                    shadow_len--;
                    a.status = sle_pkg::ST_OK;
                end
            end
            sle_pkg::OP_CLEAR: begin
                shadow_len = 0;
                a.status   = sle_pkg::ST_OK;
            end
            default: begin
            end
        endcase
        a.len = shadow_len[sle_pkg::LEN_W-1:0];
    endfunction

    task automatic add_req(input logic [sle_pkg::OP_W-1:0] op,
                           input logic [sle_pkg::POS_W-1:0] pos,
                           input logic [sle_pkg::VAL_W-1:0] val, input bit drain);
        t_list_req r;
        r.op    = op;
        r.pos   = pos;
        r.val   = val;
        r.drain = drain;
        list_requests.push_back(r);
        // track the length so positions can be aimed at the live list
        case (op)
            sle_pkg::OP_INSERT: begin
                if (pos >= 1 && pos <= plan_len + 1 && plan_len < LIST_DEPTH) begin
                    plan_len++;
                end
            end
            sle_pkg::OP_DELETE: begin
                if (pos >= 1 && pos <= plan_len) begin
                    plan_len--;
                end
            end
            sle_pkg::OP_CLEAR: plan_len = 0;
            default: begin
            end
        endcase
    endtask

    function automatic logic [sle_pkg::VAL_W-1:0] pick_value();
        if ($urandom_range(0, 9) < 7) begin
            return value_pool[$urandom_range(0, 7)];
        end
        return $urandom();
    endfunction

    function automatic logic [sle_pkg::POS_W-1:0] pick_pos(input int hi);
        if (hi < 1 || $urandom_range(0, 9) == 0) begin
            return sle_pkg::POS_W'($urandom_range(0, 255));
        end
        return sle_pkg::POS_W'($urandom_range(1, hi));
    endfunction

    function automatic logic [sle_pkg::POS_W-1:0] any_pos();
        return sle_pkg::POS_W'($urandom_range(0, 255));
    endfunction

    task automatic add_random_req();
        int r;
        bit d;
        r = $urandom_range(0, 99);
        d = ($urandom_range(0, 149) == 0)
            && (list_requests.size() < TOTAL_ITEMS - QUIET_TAIL);
        if (r < 25 || (r >= 90 && plan_len < 64)) begin
            add_req(sle_pkg::OP_INSERT, pick_pos(plan_len + 1), pick_value(), d);
        end else if (r < 40 || r >= 90) begin
            add_req(sle_pkg::OP_DELETE, pick_pos(plan_len), $urandom(), d);
        end else if (r < 55) begin
            add_req(sle_pkg::OP_GET, pick_pos(plan_len), $urandom(), d);
        end else if (r < 67) begin
            add_req(sle_pkg::OP_LOCATE, any_pos(), pick_value(), d);
        end else if (r < 77) begin
            add_req(sle_pkg::OP_PRED, any_pos(), pick_value(), d);
        end else if (r < 87) begin
            add_req(sle_pkg::OP_SUCC, any_pos(), pick_value(), d);
        end else if (r < 89) begin
            add_req(sle_pkg::OP_CLEAR, any_pos(), $urandom(), d);
        end else begin
            add_req(OP_UNUSED, any_pos(), $urandom(), d);
        end
    endtask

    task automatic report_mismatch(input string what,
                                   input logic [sle_pkg::VAL_W-1:0] got,
                                   input logic [sle_pkg::VAL_W-1:0] want);
        if (errors < 40) begin
            $display("mismatch at %0t: %s got %h want %h", $realtime, what, got, want);
        end
        errors++;
    endtask

    // Sender: present queued items, with random idle bursts.
    always @(posedge i_clk) begin : drive_proc
        t_list_ans ans;
        logic      nv;
        if (!i_rst_n) begin
            s_valid <= 1'b0;
        end else begin
            nv = s_valid;
            if (s_valid && s_ready) begin
                apply_list_op(cur_req, ans);
                pending_answers.push_back(ans);
                issued++;
                nv = 1'b0;
                if (issued % 64 == 0) begin
                    send_idling = ($urandom_range(0, 2) != 0);
                end
                if (send_idling && issued < TOTAL_ITEMS - QUIET_TAIL
                        && $urandom_range(0, 3) == 0) begin
                    send_gap = $urandom_range(1, 18);
                end
            end
            if (!nv) begin
                if (send_gap > 0) begin
                    send_gap--;
                end else if (list_requests.size() > 0
                        && (!list_requests[0].drain || issued == rcv_cnt)) begin
                    cur_req = list_requests.pop_front();
                    nv = 1'b1;
                    s_data <= {cur_req.val, cur_req.pos};
                    s_user <= cur_req.op;
                end
            end
            s_valid    <= nv;
            tail_quiet <= (issued >= TOTAL_ITEMS - QUIET_TAIL);
        end
    end

    // Receiver ready: random stalls plus one long hold-off.
    int  stall_left = 0;
    int  long_left = 0;
    bit  long_done = 1'b0;
    bit  stall_on = 1'b1;
    int  rx_cycles = 0;
    always @(posedge i_clk) begin : ready_proc
        logic nr;
        if (!i_rst_n) begin
            m_ready <= 1'b0;
        end else begin
            rx_cycles++;
            if (rx_cycles % 200 == 0) begin
                stall_on = ($urandom_range(0, 2) != 0);
            end
            if (long_left > 0) begin
                long_left--;
                nr = 1'b0;
            end else if (!long_done && rcv_cnt >= 400) begin
                long_done = 1'b1;
                long_left = 300;
                nr = 1'b0;
            end else if (tail_quiet) begin
                nr = 1'b1;
            end else if (stall_left > 0) begin
                stall_left--;
                nr = 1'b0;
            end else if (stall_on && $urandom_range(0, 7) == 0) begin
                stall_left = $urandom_range(1, 18) - 1;
                nr = 1'b0;
            end else begin
                nr = 1'b1;
            end
            m_ready <= nr;
        end
    end

    // Check each accepted result against the oldest expected answer.
    always @(posedge i_clk) begin : check_proc
        t_list_ans want;
        if (i_rst_n && m_valid && m_ready) begin
            rcv_cnt <= rcv_cnt + 1;
            if (pending_answers.size() == 0) begin
                report_mismatch("result with no item pending",
                                m_data[sle_pkg::VAL_W-1:0], '0);
            end else begin
                want = pending_answers.pop_front();
                if (m_user !== want.status) begin
                    report_mismatch("status", sle_pkg::VAL_W'(m_user),
                                    sle_pkg::VAL_W'(want.status));
                end
                if (m_data[sle_pkg::VAL_W-1:0] !== want.value) begin
                    report_mismatch("result_value", m_data[sle_pkg::VAL_W-1:0], want.value);
                end
                if (m_data[sle_pkg::VAL_W +: sle_pkg::LEN_W] !== want.len) begin
                    report_mismatch("list_length",
                                    sle_pkg::VAL_W'(m_data[sle_pkg::VAL_W +: sle_pkg::LEN_W]),
                                    sle_pkg::VAL_W'(want.len));
                end
            end
        end
    end

    initial begin
        #2_000_000;
        $display("TB_ERROR");
        $finish;
    end

    initial begin
        value_pool[0] = 32'h8000_0000;
        value_pool[1] = 32'h7FFF_FFFF;
        value_pool[2] = 32'h0000_0000;
        value_pool[3] = 32'hFFFF_FFFF;
        for (int k = 4; k < 8; k++) begin
            value_pool[k] = $urandom();
        end

        // empty list, bad positions
        add_req(sle_pkg::OP_GET, 8'd1, 32'h0, 1'b0);
        add_req(sle_pkg::OP_DELETE, 8'd0, 32'h0, 1'b0);
        add_req(sle_pkg::OP_LOCATE, 8'd0, 32'h0, 1'b0);
        add_req(sle_pkg::OP_INSERT, 8'd0, 32'h1, 1'b0);
        add_req(sle_pkg::OP_INSERT, 8'd2, 32'h1, 1'b0);
        // build a list with extremes and a duplicate
        add_req(sle_pkg::OP_INSERT, 8'd1, 32'h8000_0000, 1'b0);
        add_req(sle_pkg::OP_INSERT, 8'd2, 32'h7FFF_FFFF, 1'b0);
        add_req(sle_pkg::OP_INSERT, 8'd1, 32'hFFFF_FFFF, 1'b0);
        add_req(sle_pkg::OP_INSERT, 8'd3, 32'h0000_0000, 1'b0);
        add_req(sle_pkg::OP_INSERT, 8'd2, 32'h7FFF_FFFF, 1'b0);
        add_req(sle_pkg::OP_GET, 8'd5, 32'hFFFF_FFFF, 1'b0);
        add_req(sle_pkg::OP_GET, 8'd6, 32'h0, 1'b0);
        add_req(sle_pkg::OP_GET, 8'd255, 32'h0, 1'b0);
        add_req(sle_pkg::OP_LOCATE, 8'd0, 32'h7FFF_FFFF, 1'b0);
        add_req(sle_pkg::OP_LOCATE, 8'd0, 32'd12345, 1'b0);
        add_req(sle_pkg::OP_PRED, 8'd0, 32'hFFFF_FFFF, 1'b0);
        add_req(sle_pkg::OP_PRED, 8'd0, 32'h0000_0000, 1'b0);
        add_req(sle_pkg::OP_SUCC, 8'd0, 32'h7FFF_FFFF, 1'b0);
        add_req(sle_pkg::OP_SUCC, 8'd0, 32'h0000_0000, 1'b0);
        add_req(sle_pkg::OP_PRED, 8'd0, 32'd12345, 1'b0);
        add_req(sle_pkg::OP_INSERT, 8'd6, 32'h5A5A_5A5A, 1'b0);
        add_req(sle_pkg::OP_SUCC, 8'd255, 32'h5A5A_5A5A, 1'b0);
        add_req(sle_pkg::OP_DELETE, 8'd7, 32'h0, 1'b0);
        add_req(sle_pkg::OP_DELETE, 8'd1, 32'h0, 1'b0);
        add_req(sle_pkg::OP_DELETE, 8'd5, 32'h0, 1'b0);
        add_req(OP_UNUSED, 8'd1, 32'h0, 1'b0);
        add_req(sle_pkg::OP_CLEAR, 8'd0, 32'h0, 1'b0);
        add_req(sle_pkg::OP_GET, 8'd1, 32'h0, 1'b0);

        repeat (650) begin
            add_random_req();
        end

        // fill to capacity, then poke at the full list
        add_req(sle_pkg::OP_CLEAR, any_pos(), $urandom(), 1'b1);
        while (plan_len < LIST_DEPTH) begin
            add_req(sle_pkg::OP_INSERT, sle_pkg::POS_W'($urandom_range(1, plan_len + 1)),
                    pick_value(), 1'b0);
        end
        add_req(sle_pkg::OP_INSERT, 8'd129, $urandom(), 1'b0);
        add_req(sle_pkg::OP_INSERT, 8'd1, $urandom(), 1'b0);
        add_req(sle_pkg::OP_INSERT, 8'd130, $urandom(), 1'b0);
        add_req(sle_pkg::OP_GET, 8'd128, $urandom(), 1'b0);
        add_req(sle_pkg::OP_GET, 8'd129, $urandom(), 1'b0);
        add_req(sle_pkg::OP_LOCATE, 8'd0, pick_value(), 1'b0);
        add_req(sle_pkg::OP_PRED, 8'd0, pick_value(), 1'b0);
        add_req(sle_pkg::OP_SUCC, 8'd0, pick_value(), 1'b0);
        add_req(sle_pkg::OP_DELETE, 8'd128, $urandom(), 1'b0);
        add_req(sle_pkg::OP_INSERT, 8'd128, pick_value(), 1'b0);
        add_req(sle_pkg::OP_DELETE, 8'd1, $urandom(), 1'b0);
        repeat (10) begin
            add_req(sle_pkg::OP_DELETE, pick_pos(plan_len), $urandom(), 1'b0);
        end

        while (list_requests.size() < TOTAL_ITEMS) begin
            add_random_req();
        end

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        do begin
            @(posedge i_clk);
        end while (list_requests.size() > 0 || s_valid || pending_answers.size() > 0);
        repeat (200) @(posedge i_clk);

        if (errors == 0 && pending_answers.size() == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
